// ===== src/pareto_front_ranker_unit_assert.svh =====
// pareto_front_ranker_unit_assert.svh: assertion macros for the ranker checker
// expects clk and arst_n in the scope of use
`ifndef PARETO_FRONT_RANKER_UNIT_ASSERT_SVH
`define PARETO_FRONT_RANKER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/prf_pkg.sv =====
// prf_pkg: item types, controller states and control structs of the pareto ranker
// no dependencies
package prf_pkg;

	localparam int unsigned IN_W  = 32;
	localparam int unsigned OUT_W = 6;

	typedef struct packed {
		logic [IN_W-1:0] objective_a;
		logic [IN_W-1:0] objective_b;
		logic [IN_W-1:0] objective_c;
		logic [IN_W-1:0] objective_d;
		logic            last_member;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] member_index;
		logic [OUT_W-1:0] front_rank;
		logic             overflow_seen;
		logic             last_result;
	} res_item_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_ROW_RD,
		S_ROW_CAP,
		S_SCAN,
		S_FLUSH,
		S_ROW_WR,
		S_LVL,
		S_PSCAN,
		S_PFLUSH,
		S_PCHK,
		S_OUT_RD,
		S_OUT_CAP,
		S_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic ready;
		logic init_run;
		logic rd_row;
		logic cap_row;
		logic scan;
		logic wr_row;
		logic open_level;
		logic peel_scan;
		logic next_level;
		logic rd_out;
		logic load_out;
		logic next_out;
		logic end_run;
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic i_last;
		logic j_last;
		logic rem_empty;
		logic out_acc;
	} status_t;

endpackage

// ===== src/pareto_front_ranker_unit.sv =====
// pareto_front_ranker_unit: nondominated front ranking, top level
// loading takes one item per cycle while item_stall is low; ranking starts after the item marked last
// the dominance scan then builds one row of dominators per member (one pair compare per cycle)
// then fronts are peeled one at a time; each result needs a rank ram read and is accepted before the next is read
// reset clears counters, flags and the sequencer; stores hold no reset value
module pareto_front_ranker_unit #(
	parameter int unsigned POP       = 64,
	parameter int unsigned OBJ_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  prf_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output prf_pkg::res_item_t result
);

	prf_pkg::cmd_t    cmd;
	prf_pkg::status_t st;

	// sequencer
	prf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// stores and counters
	prf_dp #(.POP(POP), .OBJ_WIDTH(OBJ_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.item_valid   (item_valid),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign item_stall = ~cmd.ready;

endmodule

// ===== src/prf_ram.sv =====
// prf_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module prf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/prf_ctrl.sv =====
// prf_ctrl: sequencer for load, dominance scan, front peeling and result output
// depends on prf_pkg
module prf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  prf_pkg::status_t st,
	output prf_pkg::cmd_t    cmd
);

	prf_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prf_pkg::S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			prf_pkg::S_LOAD:     if (st.load_last) state_nxt = prf_pkg::S_START;
			prf_pkg::S_START:    state_nxt = prf_pkg::S_ROW_RD;
			prf_pkg::S_ROW_RD:   state_nxt = prf_pkg::S_ROW_CAP;
			prf_pkg::S_ROW_CAP:  state_nxt = prf_pkg::S_SCAN;
			prf_pkg::S_SCAN:     if (st.i_last) state_nxt = prf_pkg::S_FLUSH;
			prf_pkg::S_FLUSH:    state_nxt = prf_pkg::S_ROW_WR;
			prf_pkg::S_ROW_WR: begin
				state_nxt = st.j_last ? prf_pkg::S_LVL : prf_pkg::S_ROW_RD;
			end
			prf_pkg::S_LVL:      state_nxt = prf_pkg::S_PSCAN;
			prf_pkg::S_PSCAN:    if (st.i_last) state_nxt = prf_pkg::S_PFLUSH;
			prf_pkg::S_PFLUSH:   state_nxt = prf_pkg::S_PCHK;
			prf_pkg::S_PCHK: begin
				state_nxt = st.rem_empty ? prf_pkg::S_OUT_RD : prf_pkg::S_LVL;
			end
			prf_pkg::S_OUT_RD:   state_nxt = prf_pkg::S_OUT_CAP;
			prf_pkg::S_OUT_CAP:  state_nxt = prf_pkg::S_OUT_WAIT;
			prf_pkg::S_OUT_WAIT: begin
				if (st.out_acc) begin
					state_nxt = st.i_last ? prf_pkg::S_LOAD : prf_pkg::S_OUT_RD;
				end
			end
			default:             state_nxt = prf_pkg::S_LOAD;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			prf_pkg::S_LOAD:     cmd.ready = 1'b1;
			prf_pkg::S_START:    cmd.init_run = 1'b1;
			prf_pkg::S_ROW_RD:   cmd.rd_row = 1'b1;
			prf_pkg::S_ROW_CAP:  cmd.cap_row = 1'b1;
			prf_pkg::S_SCAN:     cmd.scan = 1'b1;
			prf_pkg::S_FLUSH:    cmd = '0;
			prf_pkg::S_ROW_WR:   cmd.wr_row = 1'b1;
			prf_pkg::S_LVL:      cmd.open_level = 1'b1;
			prf_pkg::S_PSCAN:    cmd.peel_scan = 1'b1;
			prf_pkg::S_PFLUSH:   cmd = '0;
			prf_pkg::S_PCHK:     cmd.next_level = 1'b1;
			prf_pkg::S_OUT_RD:   cmd.rd_out = 1'b1;
			prf_pkg::S_OUT_CAP:  cmd.load_out = 1'b1;
			prf_pkg::S_OUT_WAIT: begin
				cmd.next_out = st.out_acc;
				cmd.end_run  = st.out_acc & st.i_last;
			end
			default:             cmd = '0;
		endcase
	end

endmodule

// ===== src/prf_dp.sv =====
// prf_dp: objective, dominator-row and rank stores, counters and output register
// depends on prf_pkg and prf_ram
module prf_dp #(
	parameter int unsigned POP       = 64,
	parameter int unsigned OBJ_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prf_pkg::cmd_t       cmd,
	output prf_pkg::status_t    st,
	input  logic                item_valid,
	input  prf_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output prf_pkg::res_item_t  result
);

	localparam int unsigned IW = $clog2(POP);
	localparam int unsigned CW = $clog2(POP + 1);
	localparam int unsigned SW = (OBJ_WIDTH < prf_pkg::IN_W) ? OBJ_WIDTH : prf_pkg::IN_W;
	localparam int unsigned VW = 4 * SW;

	logic [CW-1:0]  cnt_q;
	logic           ovf_q;
	logic [IW-1:0]  i_q, j_q, level_q, idx_s1;
	logic           cmp_s1, pk_s1;
	logic [VW-1:0]  objj_q, obj_rdata, obj_wdata;
	logic [POP-1:0] row_q, mrow_rdata, rem_q, snap_q;
	logic [IW-1:0]  rank_rdata, obj_raddr, mat_raddr;
	logic           load_acc, room, peel_hit;
	prf_pkg::res_item_t res_q;
	logic           res_vld_q;

	// a dominates b: no objective larger, at least one smaller
	function automatic logic dominates(input logic [VW-1:0] a, input logic [VW-1:0] b);
		logic no_worse, better;
		no_worse = 1'b1;
		better   = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (a[k*SW +: SW] > b[k*SW +: SW]) no_worse = 1'b0;
			if (a[k*SW +: SW] < b[k*SW +: SW]) better = 1'b1;
		end
		return no_worse & better;
	endfunction

	assign load_acc  = cmd.ready & item_valid;
	assign room      = cnt_q < CW'(POP);
	assign obj_wdata = {item.objective_a[SW-1:0], item.objective_b[SW-1:0],
		item.objective_c[SW-1:0], item.objective_d[SW-1:0]};
	assign obj_raddr = cmd.rd_row ? j_q : i_q;
	assign mat_raddr = i_q;
	assign peel_hit  = pk_s1 & snap_q[idx_s1] & ((mrow_rdata & snap_q) == '0);

	// status to the sequencer
	assign st.load_last = load_acc & item.last_member;
	assign st.i_last    = (CW'(i_q) + CW'(1)) == cnt_q;
	assign st.j_last    = (CW'(j_q) + CW'(1)) == cnt_q;
	assign st.rem_empty = (rem_q == '0);
	assign st.out_acc   = res_vld_q & ~result_stall;

	prf_ram #(.WIDTH(VW), .DEPTH(POP)) u_obj_ram (
		.clk   (clk),
		.we    (load_acc & room),
		.waddr (cnt_q[IW-1:0]),
		.wdata (obj_wdata),
		.raddr (obj_raddr),
		.rdata (obj_rdata)
	);

	// row j holds the dominators of individual j
	prf_ram #(.WIDTH(POP), .DEPTH(POP)) u_mat_ram (
		.clk   (clk),
		.we    (cmd.wr_row),
		.waddr (j_q),
		.wdata (row_q),
		.raddr (mat_raddr),
		.rdata (mrow_rdata)
	);

	prf_ram #(.WIDTH(IW), .DEPTH(POP)) u_rank_ram (
		.clk   (clk),
		.we    (peel_hit),
		.waddr (idx_s1),
		.wdata (level_q),
		.raddr (i_q),
		.rdata (rank_rdata)
	);

	// run counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			level_q <= '0;
			cmp_s1  <= 1'b0;
			pk_s1   <= 1'b0;
			rem_q   <= '0;
			snap_q  <= '0;
		end else begin
			cmp_s1 <= cmd.scan;
			pk_s1  <= cmd.peel_scan;
			// load counting and overflow
			if (load_acc) begin
				if (room) cnt_q <= cnt_q + CW'(1);
				else      ovf_q <= 1'b1;
			end
			if (cmd.end_run) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			// member counter shared by scans and output
			if (cmd.cap_row || cmd.open_level || cmd.next_level) i_q <= '0;
			else if (cmd.scan || cmd.peel_scan || cmd.next_out)  i_q <= i_q + IW'(1);
			// row counter
			if (cmd.init_run)    j_q <= '0;
			else if (cmd.wr_row) j_q <= j_q + IW'(1);
			// front level
			if (cmd.init_run) level_q <= '0;
			else if (cmd.next_level && !st.rem_empty) level_q <= level_q + IW'(1);
			// unranked members
			if (cmd.init_run) begin
				for (int k = 0; k < POP; k++) rem_q[k] <= CW'(k) < cnt_q;
			end else if (peel_hit) begin
				rem_q[idx_s1] <= 1'b0;
			end
			if (cmd.open_level) snap_q <= rem_q;
		end
	end

	// scan payload pipeline
	always_ff @(posedge clk) begin
		idx_s1 <= i_q;
		if (cmd.cap_row) begin
			objj_q <= obj_rdata;
			row_q  <= '0;
		end else if (cmp_s1 && dominates(obj_rdata, objj_q)) begin
			row_q[idx_s1] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_vld_q <= 1'b1;
		end else if (st.out_acc) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.member_index  <= prf_pkg::OUT_W'(i_q);
			res_q.front_rank    <= prf_pkg::OUT_W'(rank_rdata);
			res_q.overflow_seen <= ovf_q;
			res_q.last_result   <= st.i_last;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// ===== src/prf_chk.sv =====
// prf_chk: port level checks of the ranker and their bind
// depends on prf_pkg and pareto_front_ranker_unit_assert.svh
`include "pareto_front_ranker_unit_assert.svh"

module prf_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input prf_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input prf_pkg::res_item_t result
);

	// a stalled result holds
	`PRF_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

	// no loading while results are pending
	`PRF_ASSERT_NOW(a_no_load_out, result_valid, item_stall, "item taken while result pending")

	// the last item closes loading
	`PRF_ASSERT_NEXT(a_last_closes, item_valid && !item_stall && item.last_member, item_stall, "loading open after last item")

	// nothing follows the last result at once
	`PRF_ASSERT_NEXT(a_last_ends, result_valid && !result_stall && result.last_result, !result_valid, "result after last result")

endmodule

bind pareto_front_ranker_unit prf_chk u_prf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
